>>> design/tcd_pkg.sv
// Package for the tape command decoder: opcodes, action and sense codes,
// register map and the structs shared between the decoder modules.
// No dependencies.
package tcd_pkg;

  // Command opcodes
  localparam logic [7:0] OP_REWIND       = 8'h01;
  localparam logic [7:0] OP_BLOCK_LIMITS = 8'h05;
  localparam logic [7:0] OP_READ6        = 8'h08;
  localparam logic [7:0] OP_WRITE6       = 8'h0A;
  localparam logic [7:0] OP_FILEMARKS    = 8'h10;
  localparam logic [7:0] OP_SPACE        = 8'h11;
  localparam logic [7:0] OP_VERIFY       = 8'h13;

  // Result action codes
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_READ   = 3'd1;
  localparam logic [2:0] ACT_WRITE  = 3'd2;
  localparam logic [2:0] ACT_LIMITS = 3'd3;
  localparam logic [2:0] ACT_GOOD   = 3'd4;
  localparam logic [2:0] ACT_CHECK  = 3'd5;

  // Sense key and detail codes
  localparam logic [1:0] SK_NONE          = 2'd0;
  localparam logic [1:0] SK_ILLEGAL       = 2'd1;
  localparam logic [1:0] SK_BLANK         = 2'd2;
  localparam logic [1:0] SD_NONE          = 2'd0;
  localparam logic [1:0] SD_INVALID_FIELD = 2'd1;
  localparam logic [1:0] SD_END_OF_DATA   = 2'd2;

  // Space codes
  localparam logic [2:0] SPACE_BLOCKS    = 3'd0;
  localparam logic [2:0] SPACE_FILEMARKS = 3'd1;
  localparam logic [2:0] SPACE_EOD       = 3'd3;

  // Register map: register i at byte address 4*i
  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_BLOCK_LENGTH    = 2'd0;
  localparam logic [1:0] REG_FORCE_FIXED     = 2'd1;
  localparam logic [1:0] REG_CAPACITY_BLOCKS = 2'd2;

  localparam logic [15:0] BLOCK_LENGTH_RST = 16'd512;

  typedef struct packed {
    logic [7:0] op;
    logic [7:0] cdb_byte1;
    logic [7:0] cdb_byte2;
    logic [7:0] cdb_byte3;
    logic [7:0] cdb_byte4;
    logic [7:0] cdb_byte5;
  } tcd_cmd_t;

  typedef struct packed {
    logic [15:0] block_length;
    logic        force_fixed;
    logic [31:0] capacity_blocks;
  } tcd_cfg_t;

  typedef struct packed {
    logic        handled;
    logic [2:0]  action;
    logic [31:0] transfer_start;
    logic [23:0] transfer_count;
    logic [1:0]  sense_key;
    logic [1:0]  sense_detail;
    logic [23:0] max_block_length;
    logic [15:0] min_block_length;
    logic [31:0] position;
  } tcd_result_t;

endpackage

>>> design/tcd_cmd_if.sv
// Command channel: one six-byte command block per beat.
// Depends on nothing.
interface tcd_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] op;
  logic [7:0] cdb_byte1;
  logic [7:0] cdb_byte2;
  logic [7:0] cdb_byte3;
  logic [7:0] cdb_byte4;
  logic [7:0] cdb_byte5;

  modport source (
    output valid, op, cdb_byte1, cdb_byte2, cdb_byte3, cdb_byte4, cdb_byte5,
    input  ready
  );
  modport sink (
    input  valid, op, cdb_byte1, cdb_byte2, cdb_byte3, cdb_byte4, cdb_byte5,
    output ready
  );
endinterface

>>> design/tcd_rsp_if.sv
// Result channel: one decoded command result per beat.
// Depends on nothing.
interface tcd_rsp_if;
  logic        valid;
  logic        ready;
  logic        handled;
  logic [2:0]  action;
  logic [31:0] transfer_start;
  logic [23:0] transfer_count;
  logic [1:0]  sense_key;
  logic [1:0]  sense_detail;
  logic [23:0] max_block_length;
  logic [15:0] min_block_length;
  logic [31:0] position;

  modport source (
    output valid, handled, action, transfer_start, transfer_count, sense_key,
           sense_detail, max_block_length, min_block_length, position,
    input  ready
  );
  modport sink (
    input  valid, handled, action, transfer_start, transfer_count, sense_key,
           sense_detail, max_block_length, min_block_length, position,
    output ready
  );
endinterface

>>> design/tcd_cfg.sv
// APB register block for the tape command decoder: block length, quirk bit
// and medium capacity. Depends on tcd_pkg.
module tcd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tcd_pkg::tcd_cfg_t           cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_length    <= tcd_pkg::BLOCK_LENGTH_RST;
      cfg.force_fixed     <= 1'b0;
      cfg.capacity_blocks <= 32'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        tcd_pkg::REG_BLOCK_LENGTH:    cfg.block_length    <= pwdata[15:0];
        tcd_pkg::REG_FORCE_FIXED:     cfg.force_fixed     <= pwdata[0];
        tcd_pkg::REG_CAPACITY_BLOCKS: cfg.capacity_blocks <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tcd_pkg::REG_BLOCK_LENGTH:    prdata = {16'd0, cfg.block_length};
      tcd_pkg::REG_FORCE_FIXED:     prdata = {31'd0, cfg.force_fixed};
      tcd_pkg::REG_CAPACITY_BLOCKS: prdata = cfg.capacity_blocks;
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

>>> design/tcd_decode.sv
// Combinational decode of one command block against the current position
// and configuration. Depends on tcd_pkg.
module tcd_decode (
  input  tcd_pkg::tcd_cmd_t    cmd,
  input  tcd_pkg::tcd_cfg_t    cfg,
  input  logic [31:0]          pos,
  output tcd_pkg::tcd_result_t res
);

  logic [23:0] len24;
  logic [23:0] blen24;
  logic [31:0] space_cnt;
  logic [2:0]  space_code;
  logic        fixed;
  logic        flag2;
  logic [23:0] step;
  logic [31:0] pos_adv;
  logic        rd_bad;
  logic        wr_bad;

  assign len24      = {cmd.cdb_byte2, cmd.cdb_byte3, cmd.cdb_byte4};
  assign blen24     = {8'd0, cfg.block_length};
  assign space_cnt  = {cmd.cdb_byte2, cmd.cdb_byte3, cmd.cdb_byte4, cmd.cdb_byte5};
  assign space_code = cmd.cdb_byte1[2:0];
  assign fixed      = cmd.cdb_byte1[0] || cfg.force_fixed;
  assign flag2      = cmd.cdb_byte1[1];
  // variable mode moves a single block; fixed mode counts blocks
  assign step       = fixed ? len24 : 24'd1;
  assign pos_adv    = pos + {8'd0, step};
  // length checks only matter in variable mode
  assign rd_bad     = !fixed && ((len24 < blen24) || ((len24 > blen24) && !flag2));
  assign wr_bad     = !fixed && (len24 != blen24);

  always_comb begin
    res                  = '0;
    res.handled          = 1'b1;
    res.action           = tcd_pkg::ACT_NONE;
    res.position         = pos;
    unique case (cmd.op)
      tcd_pkg::OP_READ6, tcd_pkg::OP_WRITE6: begin
        if ((cmd.op == tcd_pkg::OP_READ6) ? rd_bad : wr_bad) begin
          res.action       = tcd_pkg::ACT_CHECK;
          res.sense_key    = tcd_pkg::SK_ILLEGAL;
          res.sense_detail = tcd_pkg::SD_INVALID_FIELD;
        end else if (step != 24'd0) begin
          res.action         = (cmd.op == tcd_pkg::OP_READ6) ? tcd_pkg::ACT_READ
                                                             : tcd_pkg::ACT_WRITE;
          res.transfer_start = pos;
          res.transfer_count = step;
          res.position       = pos_adv;
        end else begin
          res.action = tcd_pkg::ACT_GOOD;
        end
      end
      tcd_pkg::OP_VERIFY: begin
        if (flag2) begin
          res.action       = tcd_pkg::ACT_CHECK;
          res.sense_key    = tcd_pkg::SK_ILLEGAL;
          res.sense_detail = tcd_pkg::SD_INVALID_FIELD;
        end else begin
          res.action   = tcd_pkg::ACT_GOOD;
          res.position = pos_adv;
        end
      end
      tcd_pkg::OP_REWIND: begin
        res.action   = tcd_pkg::ACT_GOOD;
        res.position = 32'd0;
      end
      tcd_pkg::OP_BLOCK_LIMITS: begin
        res.action           = tcd_pkg::ACT_LIMITS;
        res.max_block_length = blen24;
        res.min_block_length = cfg.block_length;
      end
      tcd_pkg::OP_FILEMARKS: begin
        res.action = tcd_pkg::ACT_GOOD;
      end
      tcd_pkg::OP_SPACE: begin
        priority if (space_code == tcd_pkg::SPACE_BLOCKS &&
                     space_cnt < cfg.capacity_blocks) begin
          res.action   = tcd_pkg::ACT_GOOD;
          res.position = space_cnt;
        end else if (space_code == tcd_pkg::SPACE_BLOCKS ||
                     space_code == tcd_pkg::SPACE_FILEMARKS ||
                     space_code == tcd_pkg::SPACE_EOD) begin
          res.action       = tcd_pkg::ACT_CHECK;
          res.sense_key    = tcd_pkg::SK_BLANK;
          res.sense_detail = tcd_pkg::SD_END_OF_DATA;
        end else begin
          res.action = tcd_pkg::ACT_GOOD;
        end
      end
      default: begin
        res.handled = 1'b0;
      end
    endcase
  end

endmodule

>>> design/tape_command_decoder_top.sv
// Tape command decoder top level: input register, decode, result register
// and position register; uses tcd_pkg, tcd_cfg, tcd_decode and the channels.
// Commands pass the input register, then the result register. Throughput:
// one command per cycle unless rsp stalls, set by one decode-and-add path.
// Reset clears both valid flags and the position; the registers come up with
// block length 512, fixed mode not forced and capacity 0.
module tape_command_decoder_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  tcd_cmd_if.sink                     cmd,
  tcd_rsp_if.source                   rsp
);

  tcd_pkg::tcd_cfg_t    cfg;
  tcd_pkg::tcd_cmd_t    s1_cmd;
  tcd_pkg::tcd_result_t dec_res;
  tcd_pkg::tcd_result_t out_res;
  logic                 s1_valid;
  logic                 s1_advance;
  logic                 out_valid;
  logic [31:0]          position;

  tcd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcd_decode u_decode (
    .cmd (s1_cmd),
    .cfg (cfg),
    .pos (position),
    .res (dec_res)
  );

  assign s1_advance = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_cmd <= '{op:        cmd.op,
                  cdb_byte1: cmd.cdb_byte1,
                  cdb_byte2: cmd.cdb_byte2,
                  cdb_byte3: cmd.cdb_byte3,
                  cdb_byte4: cmd.cdb_byte4,
                  cdb_byte5: cmd.cdb_byte5};
    end
  end

  // position moves at the same edge the result is captured, so the next
  // command in the input register already sees it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      position  <= 32'd0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
      position  <= dec_res.position;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res <= dec_res;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.handled          = out_res.handled;
  assign rsp.action           = out_res.action;
  assign rsp.transfer_start   = out_res.transfer_start;
  assign rsp.transfer_count   = out_res.transfer_count;
  assign rsp.sense_key        = out_res.sense_key;
  assign rsp.sense_detail     = out_res.sense_detail;
  assign rsp.max_block_length = out_res.max_block_length;
  assign rsp.min_block_length = out_res.min_block_length;
  assign rsp.position         = out_res.position;

  a_held_cmd_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid)
    else $error("buffered command lost while stalled");

  a_xfer_moves_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.action == tcd_pkg::ACT_READ ||
                  out_res.action == tcd_pkg::ACT_WRITE)
    |-> out_res.transfer_count != 24'd0 &&
        out_res.position == out_res.transfer_start + {8'd0, out_res.transfer_count})
    else $error("transfer result inconsistent with position");

  a_unhandled_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.handled
    |-> out_res.action == tcd_pkg::ACT_NONE && out_res.sense_key == tcd_pkg::SK_NONE)
    else $error("unhandled opcode produced an action");

  a_check_has_sense: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.action == tcd_pkg::ACT_CHECK
    |-> out_res.sense_key != tcd_pkg::SK_NONE)
    else $error("check condition without sense key");

  a_pos_tracks_result: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> position == out_res.position)
    else $error("position register out of step with result");

endmodule

>>> sim/tcd_checker.sv
// Scoreboard for the tape command decoder: snoops register writes and both
// channels, predicts each result beat and compares it field by field.
// Depends on tcd_pkg, tcd_cmd_if and tcd_rsp_if.
module tcd_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  tcd_cmd_if                          cmd,
  tcd_rsp_if                          rsp,
  output int                          fail_count,
  output int                          results_owed
);

  // shadow of the decoder state and registers
  logic [31:0] shadow_pos;
  logic [15:0] blk_len;
  logic        quirk;
  logic [31:0] capacity;

  tcd_pkg::tcd_result_t owed_results[$];
  int                   mismatches = 0;
  int                   strays = 0;
  int                   owed = 0;

  assign fail_count   = mismatches + strays;
  assign results_owed = owed;

  function automatic tcd_pkg::tcd_result_t decode_command(tcd_pkg::tcd_cmd_t c);
    tcd_pkg::tcd_result_t r;
    logic [23:0] len;
    logic [23:0] blocks;
    logic [31:0] space_cnt;
    logic        fixed;
    logic        flag2;
    logic        bad;
    r         = '0;
    r.handled = 1'b1;
    len       = {c.cdb_byte2, c.cdb_byte3, c.cdb_byte4};
    space_cnt = {c.cdb_byte2, c.cdb_byte3, c.cdb_byte4, c.cdb_byte5};
    fixed     = c.cdb_byte1[0] | quirk;
    flag2     = c.cdb_byte1[1];
    case (c.op)
      tcd_pkg::OP_READ6, tcd_pkg::OP_WRITE6: begin
        blocks = fixed ? len : 24'd1;
        bad    = 1'b0;
        if (!fixed) begin
          if (c.op == tcd_pkg::OP_READ6)
            bad = (len < blk_len) || (len > blk_len && !flag2);
          else
            bad = (len != blk_len);
        end
        if (bad) begin
          r.action       = tcd_pkg::ACT_CHECK;
          r.sense_key    = tcd_pkg::SK_ILLEGAL;
          r.sense_detail = tcd_pkg::SD_INVALID_FIELD;
        end else if (blocks != 0) begin
          r.action         = (c.op == tcd_pkg::OP_READ6) ? tcd_pkg::ACT_READ
                                                         : tcd_pkg::ACT_WRITE;
          r.transfer_start = shadow_pos;
          r.transfer_count = blocks;
          shadow_pos       = shadow_pos + 32'(blocks);
        end else begin
          r.action = tcd_pkg::ACT_GOOD;
        end
      end
      tcd_pkg::OP_VERIFY: begin
        if (flag2) begin
          r.action       = tcd_pkg::ACT_CHECK;
          r.sense_key    = tcd_pkg::SK_ILLEGAL;
          r.sense_detail = tcd_pkg::SD_INVALID_FIELD;
        end else begin
          r.action   = tcd_pkg::ACT_GOOD;
          shadow_pos = shadow_pos + (fixed ? 32'(len) : 32'd1);
        end
      end
      tcd_pkg::OP_REWIND: begin
        shadow_pos = '0;
        r.action   = tcd_pkg::ACT_GOOD;
      end
      tcd_pkg::OP_BLOCK_LIMITS: begin
        r.action           = tcd_pkg::ACT_LIMITS;
        r.max_block_length = 24'(blk_len);
        r.min_block_length = blk_len;
      end
      tcd_pkg::OP_FILEMARKS: r.action = tcd_pkg::ACT_GOOD;
      tcd_pkg::OP_SPACE: begin
        if (c.cdb_byte1[2:0] == tcd_pkg::SPACE_BLOCKS && space_cnt < capacity) begin
          shadow_pos = space_cnt;
          r.action   = tcd_pkg::ACT_GOOD;
        end else if (c.cdb_byte1[2:0] == tcd_pkg::SPACE_BLOCKS ||
                     c.cdb_byte1[2:0] == tcd_pkg::SPACE_FILEMARKS ||
                     c.cdb_byte1[2:0] == tcd_pkg::SPACE_EOD) begin
          r.action       = tcd_pkg::ACT_CHECK;
          r.sense_key    = tcd_pkg::SK_BLANK;
          r.sense_detail = tcd_pkg::SD_END_OF_DATA;
        end else begin
          r.action = tcd_pkg::ACT_GOOD;
        end
      end
      default: r.handled = 1'b0;
    endcase
    r.position = shadow_pos;
    return r;
  endfunction

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    tcd_pkg::tcd_cmd_t    cmd_beat;
    tcd_pkg::tcd_result_t got;
    tcd_pkg::tcd_result_t want;
    if (rst) begin
      shadow_pos = '0;
      blk_len    = tcd_pkg::BLOCK_LENGTH_RST;
      quirk      = 1'b0;
      capacity   = '0;
      owed_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          tcd_pkg::REG_BLOCK_LENGTH:    blk_len  = pwdata[15:0];
          tcd_pkg::REG_FORCE_FIXED:     quirk    = pwdata[0];
          tcd_pkg::REG_CAPACITY_BLOCKS: capacity = pwdata;
          default: ;
        endcase
      end
      // check the result beat first: it can never belong to this cycle's command
      if (rsp.valid && rsp.ready) begin
        got = {rsp.handled, rsp.action, rsp.transfer_start, rsp.transfer_count,
               rsp.sense_key, rsp.sense_detail, rsp.max_block_length,
               rsp.min_block_length, rsp.position};
        if (owed_results.size() == 0) begin
          if (strays < 10)
            $display("%0t: result beat with nothing expected: %p", $realtime, got);
          strays++;
        end else begin
          want = owed_results.pop_front();
          cmp_field("handled", 32'(want.handled), 32'(got.handled));
          cmp_field("action", 32'(want.action), 32'(got.action));
          cmp_field("transfer_start", want.transfer_start, got.transfer_start);
          cmp_field("transfer_count", 32'(want.transfer_count), 32'(got.transfer_count));
          cmp_field("sense_key", 32'(want.sense_key), 32'(got.sense_key));
          cmp_field("sense_detail", 32'(want.sense_detail), 32'(got.sense_detail));
          cmp_field("max_block_length", 32'(want.max_block_length),
                    32'(got.max_block_length));
          cmp_field("min_block_length", 32'(want.min_block_length),
                    32'(got.min_block_length));
          cmp_field("position", want.position, got.position);
        end
      end
      if (cmd.valid && cmd.ready) begin
        cmd_beat = {cmd.op, cmd.cdb_byte1, cmd.cdb_byte2, cmd.cdb_byte3,
                    cmd.cdb_byte4, cmd.cdb_byte5};
        owed_results.push_back(decode_command(cmd_beat));
      end
    end
    owed = owed_results.size();
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the tape command decoder: clock, reset, register writes,
// command stimulus and result backpressure; the verdict comes from tcd_checker.
// Depends on tcd_pkg, tcd_cmd_if, tcd_rsp_if, tcd_checker and the decoder RTL.
module tb_top;

  localparam int ITEMS_PER_SEG = 117;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [tcd_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  int                          fails;
  int                          owed;

  int          src_idle_pct = 8;
  int          snk_idle_pct = 48;
  logic [15:0] cur_bl = tcd_pkg::BLOCK_LENGTH_RST;
  logic [31:0] cur_cap = '0;

  tcd_cmd_if cmd_ch ();
  tcd_rsp_if rsp_ch ();

  tape_command_decoder_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch)
  );

  tcd_checker chk (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .cmd          (cmd_ch),
    .rsp          (rsp_ch),
    .fail_count   (fails),
    .results_owed (owed)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    rsp_ch.ready = ($urandom_range(0, 99) >= snk_idle_pct);
  end

  task automatic send_cmd(tcd_pkg::tcd_cmd_t c);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid = 1'b1;
    {cmd_ch.op, cmd_ch.cdb_byte1, cmd_ch.cdb_byte2, cmd_ch.cdb_byte3,
     cmd_ch.cdb_byte4, cmd_ch.cdb_byte5} = c;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // stop sending and wait for every owed result beat
  task automatic drain();
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (owed != 0) @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(logic [15:0] bl, logic quirk, logic [31:0] cap);
    drain();
    reg_write(tcd_pkg::REG_BLOCK_LENGTH, 32'(bl));
    reg_write(tcd_pkg::REG_FORCE_FIXED, 32'(quirk));
    reg_write(tcd_pkg::REG_CAPACITY_BLOCKS, cap);
    cur_bl  = bl;
    cur_cap = cap;
  endtask

  task automatic random_config();
    logic [15:0] bl;
    logic [31:0] cap;
    case ($urandom_range(0, 4))
      0: bl = 16'd1;
      1: bl = 16'hFFFF;
      2: bl = 16'd512;
      3: bl = 16'($urandom_range(1, 64));
      default: bl = 16'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 3))
      0: cap = '0;
      1: cap = 32'hFFFF_FFFF;
      2: cap = 32'($urandom_range(1, 4096));
      default: cap = $urandom;
    endcase
    set_config(bl, 1'($urandom_range(0, 1)), cap);
  endtask

  // mostly legal commands, lengths biased around the block length
  function automatic tcd_pkg::tcd_cmd_t rand_cmd();
    tcd_pkg::tcd_cmd_t c;
    int                pick;
    logic [23:0]       len;
    logic [2:0]        code;
    c.cdb_byte1 = 8'($urandom_range(0, 255));
    {c.cdb_byte2, c.cdb_byte3, c.cdb_byte4, c.cdb_byte5} = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: len = 24'(cur_bl);
      4:          len = 24'(cur_bl) - 24'd1;
      5:          len = 24'(cur_bl) + 24'd1;
      6, 7:       len = 24'($urandom_range(0, 64));
      default:    len = 24'($urandom_range(0, 24'hFF_FFFF));
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 25)      c.op = tcd_pkg::OP_READ6;
    else if (pick < 45) c.op = tcd_pkg::OP_WRITE6;
    else if (pick < 55) c.op = tcd_pkg::OP_VERIFY;
    else if (pick < 61) c.op = tcd_pkg::OP_REWIND;
    else if (pick < 67) c.op = tcd_pkg::OP_BLOCK_LIMITS;
    else if (pick < 72) c.op = tcd_pkg::OP_FILEMARKS;
    else if (pick < 87) c.op = tcd_pkg::OP_SPACE;
    else                c.op = 8'($urandom_range(0, 255));
    if (c.op == tcd_pkg::OP_READ6 || c.op == tcd_pkg::OP_WRITE6 ||
        c.op == tcd_pkg::OP_VERIFY) begin
      {c.cdb_byte2, c.cdb_byte3, c.cdb_byte4} = len;
    end else if (c.op == tcd_pkg::OP_SPACE) begin
      code = $urandom_range(0, 1) ? tcd_pkg::SPACE_BLOCKS : 3'($urandom_range(0, 7));
      c.cdb_byte1[2:0] = code;
      if (code == tcd_pkg::SPACE_BLOCKS && cur_cap != 0 && $urandom_range(0, 1))
        {c.cdb_byte2, c.cdb_byte3, c.cdb_byte4, c.cdb_byte5} = $urandom % cur_cap;
    end
    return c;
  endfunction

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.op        = '0;
    cmd_ch.cdb_byte1 = '0;
    cmd_ch.cdb_byte2 = '0;
    cmd_ch.cdb_byte3 = '0;
    cmd_ch.cdb_byte4 = '0;
    cmd_ch.cdb_byte5 = '0;
    rsp_ch.ready     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: block length 512, variable mode, empty medium
    send_cmd({tcd_pkg::OP_READ6, 8'h00, 24'h000200, 8'h00});
    send_cmd({tcd_pkg::OP_READ6, 8'h00, 24'h0001FF, 8'h00});
    send_cmd({tcd_pkg::OP_READ6, 8'h00, 24'h000201, 8'h00});
    send_cmd({tcd_pkg::OP_READ6, 8'h02, 24'h000201, 8'h00});
    send_cmd({tcd_pkg::OP_WRITE6, 8'h00, 24'h000200, 8'h00});
    send_cmd({tcd_pkg::OP_WRITE6, 8'h00, 24'h000201, 8'h00});
    send_cmd({tcd_pkg::OP_READ6, 8'h01, 24'h000000, 8'h00});
    send_cmd({tcd_pkg::OP_READ6, 8'hFF, 24'hFFFFFF, 8'hFF});
    send_cmd({tcd_pkg::OP_WRITE6, 8'h01, 24'hFFFFFF, 8'h00});
    send_cmd({tcd_pkg::OP_VERIFY, 8'h02, 24'h000010, 8'h00});
    send_cmd({tcd_pkg::OP_VERIFY, 8'h00, 24'h000010, 8'h00});
    send_cmd({tcd_pkg::OP_VERIFY, 8'h01, 24'h000010, 8'h00});
    send_cmd({tcd_pkg::OP_BLOCK_LIMITS, 8'h00, 24'h000000, 8'h00});
    send_cmd({tcd_pkg::OP_FILEMARKS, 8'hFF, 24'hFFFFFF, 8'hFF});
    send_cmd({tcd_pkg::OP_SPACE, 8'h00, 24'h000000, 8'h00});
    send_cmd({tcd_pkg::OP_SPACE, 8'h01, 24'h000000, 8'h05});
    send_cmd({tcd_pkg::OP_SPACE, 8'h03, 24'h000000, 8'h05});
    send_cmd({tcd_pkg::OP_SPACE, 8'hFA, 24'h000000, 8'h05});
    send_cmd({tcd_pkg::OP_REWIND, 8'h00, 24'h000000, 8'h00});
    send_cmd({8'h00, 8'h00, 24'h000000, 8'h00});
    send_cmd({8'hFF, 8'hFF, 24'hFFFFFF, 8'hFF});

    // forced fixed mode, full medium: wrap the position
    set_config(16'd1, 1'b1, 32'hFFFF_FFFF);
    send_cmd({tcd_pkg::OP_SPACE, 8'h00, 32'hFFFF_FFF0});
    send_cmd({tcd_pkg::OP_READ6, 8'h00, 24'h000020, 8'h00});
    send_cmd({tcd_pkg::OP_VERIFY, 8'h00, 24'hFFFFFF, 8'h00});
    send_cmd({tcd_pkg::OP_SPACE, 8'hF8, 32'hFFFF_FFFF});

    set_config(16'hFFFF, 1'b0, 32'd1000);
    send_cmd({tcd_pkg::OP_WRITE6, 8'h00, 24'h00FFFF, 8'h00});
    send_cmd({tcd_pkg::OP_READ6, 8'h02, 24'hFFFFFF, 8'h00});
    send_cmd({tcd_pkg::OP_SPACE, 8'h00, 32'd999});
    send_cmd({tcd_pkg::OP_SPACE, 8'h00, 32'd1000});
    send_cmd({tcd_pkg::OP_BLOCK_LIMITS, 8'h00, 24'h000000, 8'h00});

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          src_idle_pct = 8;
          snk_idle_pct = 48;
        end
        1: begin
          src_idle_pct = 48;
          snk_idle_pct = 8;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      random_config();
      for (int n = 0; n < ITEMS_PER_SEG; n++) begin
        send_cmd(rand_cmd());
        if (seg == 3 && n == ITEMS_PER_SEG / 2) drain();
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (fails == 0 && owed == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> tape_command_decoder_top.f
design/tcd_pkg.sv
design/tcd_cmd_if.sv
design/tcd_rsp_if.sv
design/tcd_cfg.sv
design/tcd_decode.sv
design/tape_command_decoder_top.sv
sim/tcd_checker.sv
sim/tb_top.sv
